// File: rtl/core/stable_priority_queue_defines.svh
// Assertion macros used by the checker file spq_checker.sv.
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// Check a property on every rising edge of clk, outside reset.
`define SPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a trigger is followed by a consequence on the next edge.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/spq_pkg.sv
package spq_pkg;

    // Widest tag the storage may be configured for.
    localparam int TAG_MAX_BITS = 64;

    localparam logic [1:0] STATUS_ENQ   = 2'd0;
    localparam logic [1:0] STATUS_DEQ   = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;
    localparam logic [1:0] STATUS_FULL  = 2'd3;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [2:0]  priority_req;
        logic [31:0] tag;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  out_priority;
        logic [31:0] out_tag;
        logic [6:0]  occupancy;
    } result_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic tag_we;
        logic link_we;
    } mem_ctl_t;

endpackage

// File: rtl/core/spq_store.sv
module spq_store #(
    parameter int DEPTH    = 64,
    parameter int TAG_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spq_pkg::mem_ctl_t    ctl,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic [$clog2(DEPTH)-1:0] tag_addr,
    input  logic [TAG_BITS-1:0]  tag_wdata,
    input  logic [$clog2(DEPTH)-1:0] link_addr,
    input  logic [$clog2(DEPTH)-1:0] link_wdata,
    output logic [TAG_BITS-1:0]  rd_tag,
    output logic [$clog2(DEPTH)-1:0] rd_link
);

    localparam int AW = $clog2(DEPTH);

    logic [TAG_BITS-1:0] tag_mem [DEPTH];
    logic [AW-1:0]       link_mem [DEPTH];

    logic [TAG_BITS-1:0] rd_tag_reg;
    logic [AW-1:0]       link_q_reg;
    logic [AW-1:0]       rd_addr_reg;

    // Slots at or above this mark were never allocated; their link is the
    // free chain successor.
    logic [AW:0] fresh_reg;
    logic [AW:0] fresh_next;
    logic [AW-1:0] succ;

    always_ff @(posedge clk)
    begin
        if (ctl.tag_we)
        begin
            tag_mem[tag_addr] <= tag_wdata;
        end
        if (ctl.link_we)
        begin
            link_mem[link_addr] <= link_wdata;
        end
        if (ctl.rd_en)
        begin
            rd_tag_reg  <= tag_mem[rd_addr];
            link_q_reg  <= link_mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_comb
    begin
        fresh_next = fresh_reg;
        if (ctl.tag_we && ({1'b0, tag_addr} == fresh_reg))
        begin
            fresh_next = (AW+1)'(fresh_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg <= '0;
        end
        else
        begin
            fresh_reg <= fresh_next;
        end
    end

    always_comb
    begin
        succ = (rd_addr_reg == AW'(DEPTH - 1)) ? '0 : AW'(rd_addr_reg + 1'b1);
    end

    assign rd_tag  = rd_tag_reg;
    assign rd_link = ({1'b0, rd_addr_reg} >= fresh_reg) ? succ : link_q_reg;

endmodule

// File: rtl/core/stable_priority_queue.sv
// A command transferred while idle reads the link and tag memories; busy is then high
// in EXEC for the write-back, and the result shows with done high in the cycle after.
// No new command is taken while busy, because of the read then write-back of the
// link and tag memories. The receiver cannot stall; done lasts exactly one cycle.
// Reset (rst_n low, asynchronous): queue empty, free chain in slot order, no clearing
// pass; the block takes a command in the first cycle after reset is released.
module stable_priority_queue #(
    parameter int QUEUE_DEPTH = 64,
    parameter int NUM_CLASSES = 5,
    parameter int TAG_BITS    = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  spq_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done,
    output spq_pkg::result_t result
);

    localparam int AW   = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW   = $clog2(NUM_CLASSES);

    spq_pkg::state_t  state_reg;
    spq_pkg::state_t  state_next;
    logic             exec;
    logic             accept;

    spq_pkg::cmd_t    cmd_reg;
    spq_pkg::cmd_t    act_cmd;

    // Per-class list heads and tails, plus the free list head.
    logic [AW-1:0]          class_head_reg [NUM_CLASSES];
    logic [AW-1:0]          class_head_next [NUM_CLASSES];
    logic [AW-1:0]          class_tail_reg [NUM_CLASSES];
    logic [AW-1:0]          class_tail_next [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] nonempty_reg;
    logic [NUM_CLASSES-1:0] nonempty_next;
    logic [AW-1:0]          free_head_reg;
    logic [AW-1:0]          free_head_next;
    logic [CNTW-1:0]        count_reg;
    logic [CNTW-1:0]        count_next;

    spq_pkg::result_t result_reg;
    spq_pkg::result_t result_next;
    logic             done_reg;
    logic             done_next;

    logic [CW-1:0] req_cls;
    logic [CW-1:0] sel_cls;
    logic [CW-1:0] idx;
    logic          any;
    logic [AW-1:0] head_sel;
    logic [AW-1:0] tail_sel;
    logic          ne_sel;

    spq_pkg::mem_ctl_t mem_ctl;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       link_addr;
    logic [AW-1:0]       link_wdata;
    logic [TAG_BITS-1:0] tag_wdata;
    logic [TAG_BITS-1:0] rd_tag;
    logic [AW-1:0]       rd_link;
    logic [spq_pkg::TAG_MAX_BITS-1:0] tag_wide_in;
    logic [spq_pkg::TAG_MAX_BITS-1:0] tag_wide_out;

    // ---------------------------------------------------------------
    // Control: IDLE takes a transfer, EXEC does the write-back.
    // ---------------------------------------------------------------
    always_comb
    begin
        case (state_reg)
            spq_pkg::ST_IDLE: state_next = accept ? spq_pkg::ST_EXEC : spq_pkg::ST_IDLE;
            spq_pkg::ST_EXEC: state_next = spq_pkg::ST_IDLE;
            default:          state_next = spq_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            spq_pkg::ST_EXEC:
            begin
                busy = 1'b1;
                exec = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
                exec = 1'b0;
            end
        endcase
    end

    assign accept = start && !busy;

    // Work on the held command during EXEC and on the incoming one otherwise,
    // so one class index serves the memory read and the write-back.
    assign act_cmd = busy ? cmd_reg : cmd;

    // Saturate an out-of-range class to the least urgent one.
    always_comb
    begin
        if (32'(act_cmd.priority_req) >= NUM_CLASSES)
        begin
            req_cls = CW'(NUM_CLASSES - 1);
        end
        else
        begin
            req_cls = CW'(act_cmd.priority_req);
        end
    end

    // Pick the most urgent class that holds an entry.
    always_comb
    begin
        sel_cls = '0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            if (nonempty_reg[i])
            begin
                sel_cls = CW'(i);
            end
        end
    end

    assign any      = |nonempty_reg;
    assign idx      = (act_cmd.operation == spq_pkg::OP_DEQ) ? sel_cls : req_cls;
    assign head_sel = class_head_reg[idx];
    assign tail_sel = class_tail_reg[idx];
    assign ne_sel   = nonempty_reg[idx];

    // Read the slot that the command will touch: the free head for an
    // enqueue, the head of the chosen class for a dequeue.
    assign rd_addr = (act_cmd.operation == spq_pkg::OP_DEQ) ? head_sel : free_head_reg;

    assign tag_wide_in  = spq_pkg::TAG_MAX_BITS'(cmd_reg.tag);
    assign tag_wdata    = tag_wide_in[TAG_BITS-1:0];
    assign tag_wide_out = spq_pkg::TAG_MAX_BITS'(rd_tag);

    // ---------------------------------------------------------------
    // Write-back: update the lists from the read data and form the result.
    // ---------------------------------------------------------------
    always_comb
    begin
        class_head_next = class_head_reg;
        class_tail_next = class_tail_reg;
        nonempty_next   = nonempty_reg;
        free_head_next  = free_head_reg;
        count_next      = count_reg;
        result_next     = result_reg;
        done_next       = 1'b0;
        mem_ctl.rd_en   = accept;
        mem_ctl.tag_we  = 1'b0;
        mem_ctl.link_we = 1'b0;
        link_addr       = free_head_reg;
        link_wdata      = free_head_reg;

        if (exec)
        begin
            done_next   = 1'b1;
            result_next = '0;
            if (cmd_reg.operation == spq_pkg::OP_ENQ)
            begin
                if (count_reg == CNTW'(QUEUE_DEPTH))
                begin
                    // Refuse the entry; hold all state.
                    result_next.status = spq_pkg::STATUS_FULL;
                end
                else
                begin
                    mem_ctl.tag_we = 1'b1;
                    if (ne_sel)
                    begin
                        // Append behind the current tail.
                        mem_ctl.link_we = 1'b1;
                        link_addr       = tail_sel;
                        link_wdata      = free_head_reg;
                    end
                    else
                    begin
                        class_head_next[idx] = free_head_reg;
                    end
                    class_tail_next[idx] = free_head_reg;
                    nonempty_next[idx]   = 1'b1;
                    free_head_next       = rd_link;
                    count_next           = CNTW'(count_reg + 1'b1);
                    result_next.status   = spq_pkg::STATUS_ENQ;
                end
            end
            else
            begin
                if (!any)
                begin
                    result_next.status = spq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    // Drop the head slot of the class and push it onto the free list.
                    if (head_sel == tail_sel)
                    begin
                        nonempty_next[idx] = 1'b0;
                    end
                    else
                    begin
                        class_head_next[idx] = rd_link;
                    end
                    mem_ctl.link_we          = 1'b1;
                    link_addr                = head_sel;
                    link_wdata               = free_head_reg;
                    free_head_next           = head_sel;
                    count_next               = CNTW'(count_reg - 1'b1);
                    result_next.status       = spq_pkg::STATUS_DEQ;
                    result_next.out_priority = 3'(idx);
                    result_next.out_tag      = tag_wide_out[31:0];
                end
            end
            result_next.occupancy = 7'(count_next);
        end
    end

    spq_store #(
        .DEPTH    (QUEUE_DEPTH),
        .TAG_BITS (TAG_BITS)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mem_ctl),
        .rd_addr    (rd_addr),
        .tag_addr   (free_head_reg),
        .tag_wdata  (tag_wdata),
        .link_addr  (link_addr),
        .link_wdata (link_wdata),
        .rd_tag     (rd_tag),
        .rd_link    (rd_link)
    );

    // Hold the command payload for the write-back cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::ST_IDLE;
            nonempty_reg  <= '0;
            free_head_reg <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                class_head_reg[i] <= '0;
                class_tail_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            nonempty_reg   <= nonempty_next;
            free_head_reg  <= free_head_next;
            count_reg      <= count_next;
            done_reg       <= done_next;
            class_head_reg <= class_head_next;
            class_tail_reg <= class_tail_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: rtl/core/spq_checker.sv
`include "stable_priority_queue_defines.svh"

module spq_checker #(
    parameter int QUEUE_DEPTH = 64
) (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input spq_pkg::result_t result
);

    logic xfer;
    logic empty_rpt;
    logic full_rpt;
    logic full_ok;

    assign xfer      = start && !busy;
    assign empty_rpt = done && (result.status == spq_pkg::STATUS_EMPTY);
    assign full_rpt  = done && (result.status == spq_pkg::STATUS_FULL);
    assign full_ok   = (result.occupancy == 7'(QUEUE_DEPTH)) && (result.out_tag == 32'd0);

    // A transfer makes the block busy for one cycle, then shows its result.
    `SPQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, xfer, busy && !done, "busy missing after transfer")
    `SPQ_ASSERT(a_accept_done, clk, rst_n, xfer |=> ##1 done, "result missing after transfer")
    `SPQ_ASSERT(a_done_after_busy, clk, rst_n, done |-> $past(busy), "result without busy cycle")
    `SPQ_ASSERT(a_empty_occ, clk, rst_n, empty_rpt |-> (result.occupancy == 7'd0), "empty with entries")
    `SPQ_ASSERT(a_full_occ, clk, rst_n, full_rpt |-> full_ok, "full report with wrong occupancy or tag")

endmodule

bind stable_priority_queue spq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
